// File: sv/sst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

    localparam int CAPACITY_DEFAULT = 16;
    localparam int KEY_W            = 32;
    localparam int ACTION_W         = 2;
    localparam int COUNT_W          = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERTED = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVED  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DROPPED  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CHECK,
        ST_RM_RD,
        ST_RM_WR,
        ST_INS_RD,
        ST_INS_WR,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic                load_key;
        logic                search_rd;
        logic                pos_inc;
        logic                rm_start;
        logic                rm_rd;
        logic                rm_wr;
        logic                ins_start;
        logic                ins_rd;
        logic                ins_wr;
        logic                key_wr;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                set_act;
        logic [ACTION_W-1:0] act;
        logic                load_result;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pos_at_end;
        logic key_lt;
        logic key_eq;
        logic full;
        logic rm_more;
        logic ins_more;
    } status_t;

endpackage

`default_nettype wire

// File: sv/sst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/sst_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sst_datapath #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire sst_pkg::cmd_t                  cmd,
    output sst_pkg::status_t                    status,
    input  wire logic signed [sst_pkg::KEY_W-1:0] s_key,
    output logic [sst_pkg::ACTION_W-1:0]        m_action,
    output logic [sst_pkg::COUNT_W-1:0]         m_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic signed [sst_pkg::KEY_W-1:0] key_reg;
    logic [CW-1:0]                    pos_reg, pos_next;
    logic [CW-1:0]                    idx_reg, idx_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [sst_pkg::ACTION_W-1:0]     act_reg, act_next;
    logic [sst_pkg::ACTION_W-1:0]     action_reg;
    logic [sst_pkg::COUNT_W-1:0]      entry_count_reg;

    logic                      ram_rd_en, ram_wr_en;
    logic [CW-1:0]             rd_sel, wr_sel;
    logic [sst_pkg::KEY_W-1:0] ram_wr_data, ram_rd_data;
    logic signed [sst_pkg::KEY_W-1:0] entry;
    logic [CW-1:0]             idx_up, idx_dn;
    logic [31:0]               count_wide;

    assign idx_up     = idx_reg + ONE_C;
    assign idx_dn     = idx_reg - ONE_C;
    assign entry      = $signed(ram_rd_data);
    assign count_wide = 32'(count_next);

    // port selection
    always_comb begin
        ram_rd_en   = cmd.search_rd | cmd.rm_rd | cmd.ins_rd;
        ram_wr_en   = cmd.rm_wr | cmd.ins_wr | cmd.key_wr;
        rd_sel      = pos_reg;
        wr_sel      = idx_reg;
        ram_wr_data = ram_rd_data;
        if (cmd.rm_rd) begin
            rd_sel = idx_up;
        end else if (cmd.ins_rd) begin
            rd_sel = idx_dn;
        end
        if (cmd.key_wr) begin
            wr_sel      = pos_reg;
            ram_wr_data = key_reg;
        end
    end

    sst_ram #(
        .WIDTH(sst_pkg::KEY_W),
        .DEPTH(CAPACITY)
    ) u_keys (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(wr_sel[AW-1:0]),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(rd_sel[AW-1:0]),
        .rd_data(ram_rd_data)
    );

    always_comb begin
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        act_next   = act_reg;
        if (cmd.load_key) begin
            pos_next = '0;
        end else if (cmd.pos_inc) begin
            pos_next = pos_reg + ONE_C;
        end
        if (cmd.rm_start) begin
            idx_next = pos_reg;
        end else if (cmd.ins_start) begin
            idx_next = count_reg;
        end else if (cmd.rm_wr) begin
            idx_next = idx_up;
        end else if (cmd.ins_wr) begin
            idx_next = idx_dn;
        end
        if (cmd.cnt_inc) begin
            count_next = count_reg + ONE_C;
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - ONE_C;
        end
        if (cmd.set_act) begin
            act_next = cmd.act;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        act_reg <= act_next;
        if (cmd.load_key) begin
            key_reg <= s_key;
        end
        if (cmd.load_result) begin
            action_reg      <= act_reg;
            entry_count_reg <= count_wide[sst_pkg::COUNT_W-1:0];
        end
    end

    always_comb begin
        status.pos_at_end = (pos_reg == count_reg);
        status.key_lt     = (entry < key_reg);
        status.key_eq     = (entry == key_reg);
        status.full       = (count_reg >= CAP_C);
        status.rm_more    = (idx_up < count_reg);
        status.ins_more   = (idx_reg > pos_reg);
    end

    assign m_action      = action_reg;
    assign m_entry_count = entry_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_C)
        else $error("entry count beyond capacity");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_start |-> !status.full)
        else $error("insert started on a full set");

    a_remove_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rm_start |-> (count_reg != '0) && (pos_reg < count_reg))
        else $error("remove started outside the held entries");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cnt_dec |=> count_reg == $past(count_reg) - ONE_C)
        else $error("count did not drop after a removal");

endmodule

`default_nettype wire

// File: sv/sst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sst_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output sst_pkg::cmd_t         cmd,
    input  wire sst_pkg::status_t status
);

    sst_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sst_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sst_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sst_pkg::ST_SEARCH;
                end
            end
            sst_pkg::ST_SEARCH: begin
                if (!status.pos_at_end) begin
                    state_next = sst_pkg::ST_CHECK;
                end else if (status.full) begin
                    state_next = sst_pkg::ST_RESULT;
                end else begin
                    state_next = sst_pkg::ST_INS_RD;
                end
            end
            sst_pkg::ST_CHECK: begin
                priority if (status.key_lt) begin
                    state_next = sst_pkg::ST_SEARCH;
                end else if (status.key_eq) begin
                    state_next = sst_pkg::ST_RM_RD;
                end else if (status.full) begin
                    state_next = sst_pkg::ST_RESULT;
                end else begin
                    state_next = sst_pkg::ST_INS_RD;
                end
            end
            sst_pkg::ST_RM_RD: begin
                state_next = status.rm_more ? sst_pkg::ST_RM_WR : sst_pkg::ST_RESULT;
            end
            sst_pkg::ST_RM_WR: begin
                state_next = sst_pkg::ST_RM_RD;
            end
            sst_pkg::ST_INS_RD: begin
                state_next = status.ins_more ? sst_pkg::ST_INS_WR : sst_pkg::ST_RESULT;
            end
            sst_pkg::ST_INS_WR: begin
                state_next = sst_pkg::ST_INS_RD;
            end
            sst_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = sst_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sst_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd          = '0;
        cmd.act      = sst_pkg::ACT_INSERTED;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            sst_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_key = s_valid;
            end
            sst_pkg::ST_SEARCH: begin
                if (!status.pos_at_end) begin
                    cmd.search_rd = 1'b1;
                end else if (status.full) begin
                    cmd.set_act = 1'b1;
                    cmd.act     = sst_pkg::ACT_DROPPED;
                end else begin
                    cmd.ins_start = 1'b1;
                    cmd.set_act   = 1'b1;
                    cmd.act       = sst_pkg::ACT_INSERTED;
                end
            end
            sst_pkg::ST_CHECK: begin
                priority if (status.key_lt) begin
                    cmd.pos_inc = 1'b1;
                end else if (status.key_eq) begin
                    cmd.rm_start = 1'b1;
                    cmd.set_act  = 1'b1;
                    cmd.act      = sst_pkg::ACT_REMOVED;
                end else if (status.full) begin
                    cmd.set_act = 1'b1;
                    cmd.act     = sst_pkg::ACT_DROPPED;
                end else begin
                    cmd.ins_start = 1'b1;
                    cmd.set_act   = 1'b1;
                    cmd.act       = sst_pkg::ACT_INSERTED;
                end
            end
            sst_pkg::ST_RM_RD: begin
                cmd.rm_rd   = status.rm_more;
                cmd.cnt_dec = !status.rm_more;
            end
            sst_pkg::ST_RM_WR: begin
                cmd.rm_wr = 1'b1;
            end
            sst_pkg::ST_INS_RD: begin
                cmd.ins_rd  = status.ins_more;
                cmd.key_wr  = !status.ins_more;
                cmd.cnt_inc = !status.ins_more;
            end
            sst_pkg::ST_INS_WR: begin
                cmd.ins_wr = 1'b1;
            end
            sst_pkg::ST_RESULT: begin
                if (out_free) begin
                    cmd.load_result = 1'b1;
                    m_valid_next    = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    a_result_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |=> m_valid_reg)
        else $error("result loaded but not presented");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == sst_pkg::ST_SEARCH)
        else $error("accepted word did not start a search");

endmodule

`default_nettype wire

// File: sv/sorted_set_toggle_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted set toggle core. Holds up to CAPACITY distinct signed 32-bit keys in
// ascending order in a single-port-read RAM. Each word on the s_ channel
// toggles its key: a present key is removed and the entries above it close
// up; an absent key is inserted at its sorted place, or dropped (action 2)
// when the set is full. Every input word yields exactly one m_ word carrying
// the action (0 inserted, 1 removed, 2 dropped) and the count held after the
// step. One word is processed at a time: the next word is accepted only
// after the last one has been searched, its entries moved and its result
// loaded. The search walks the entries one by one, each read and then
// checked, and every entry that moves is read and then rewritten through
// the registered read port; acceptance comes first, then the search, the
// moves, the final write or check, and the loading of the result. A
// finished result sits in an output register, so the next word is taken
// while it waits; that word's own result then holds until m_ready frees
// the register. The store needs no clearing after reset; of the datapath
// registers only the count is reset.
module sorted_set_toggle_core #(
    parameter int CAPACITY = sst_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [sst_pkg::KEY_W-1:0] s_key,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [sst_pkg::ACTION_W-1:0]          m_action,
    output logic [sst_pkg::COUNT_W-1:0]           m_entry_count
);

    // command and status between sequencer and datapath
    sst_pkg::cmd_t    cmd;
    sst_pkg::status_t status;

    // sequencer: accept, search, shift, then hand the result over
    sst_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .status (status)
    );

    // datapath: key store, pointers, count and result register
    sst_datapath #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_key        (s_key),
        .m_action     (m_action),
        .m_entry_count(m_entry_count)
    );

endmodule

`default_nettype wire
